@@ design/annexb_nal_scanner_defines.svh @@
// ----------------------------------------------------------------------------
// annexb_nal_scanner_defines.svh
// Assertion macros shared by the NAL scanner RTL.
// ----------------------------------------------------------------------------
`ifndef ANNEXB_NAL_SCANNER_DEFINES_SVH
`define ANNEXB_NAL_SCANNER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ANBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ANBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/anbs_pkg.sv @@
// ----------------------------------------------------------------------------
// anbs_pkg
// Types and constants for the Annex-B NAL scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package anbs_pkg;

  // Default sizes
  localparam int unsigned SetStoreBytesDefault = 256;
  localparam int unsigned MaxChunkBytesDefault = 8388608;

  // NAL unit types and framing
  localparam logic [4:0]  NalTypeMask = 5'h1f;
  localparam logic [4:0]  NalIdr      = 5'd5;
  localparam logic [4:0]  NalSps      = 5'd7;
  localparam logic [4:0]  NalPps      = 5'd8;
  localparam logic [23:0] PrefixBytes = 24'd4;
  localparam logic [23:0] LenMax      = 24'hffffff;

  // Input access kind (tuser bit 0)
  typedef enum logic {
    FUNC_STREAM = 1'b0,
    FUNC_READ   = 1'b1
  } func_e;

  // Result kind (output tuser)
  typedef enum logic {
    KIND_SUMMARY = 1'b0,
    KIND_READ    = 1'b1
  } kind_e;

  // One result item
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  read_byte;
    logic [8:0]  pps_length;
    logic [8:0]  sps_length;
    logic        has_idr;
    logic [23:0] avcc_length;
  } result_t;

endpackage

`default_nettype wire

@@ design/annexb_nal_scanner.sv @@
// Path: a chunk summary or a store read passes the result stage register and the
//   result queue to the master side; a chunk's other bytes give no result.
// Throughput: one input transfer per cycle, set by the single-port store memories
//   and the per-byte scan update; a four-entry result queue absorbs output stalls.
// Reset: asynchronous, active low; clears the scan state and captured lengths.
//   The parameter-set memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// annexb_nal_scanner
// Scans H.264 Annex-B chunks a byte per cycle unless stalled, sums length-prefixed
// sizes of non-SPS/PPS NALs, flags IDR units, captures first SPS/PPS for read-back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "annexb_nal_scanner_defines.svh"

module annexb_nal_scanner
  import anbs_pkg::*;
#(
  parameter int unsigned SetStoreBytes = SetStoreBytesDefault,
  parameter int unsigned MaxChunkBytes = MaxChunkBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] read_index
  input  wire logic        s_axis_tlast,   // chunk_last
  input  wire logic [1:0]  s_axis_tuser,   // [0] func, [1] set_select
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [23:0] avcc_length, [24] has_idr, [33:25] sps_length, [42:34] pps_length,
  // [50:43] read_byte, [55:51] zero
  output logic [55:0]      m_axis_tdata,
  output logic             m_axis_tuser    // [0] result_kind
);

  localparam int unsigned AddrW  = $clog2(SetStoreBytes);
  localparam int unsigned LenW   = $clog2(SetStoreBytes + 1);
  localparam logic [23:0] CntCap = (MaxChunkBytes < 24'hffffff) ?
                                   24'(MaxChunkBytes) : 24'hffffff;
  localparam logic [23:0] StoreLim = 24'(SetStoreBytes);
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  func_e      in_func;
  logic [7:0] in_byte;
  logic [7:0] in_index;
  logic       in_set;
  logic       in_last;
  logic       s_acc;
  logic       acc_stream;
  logic       acc_read;

  assign in_func    = func_e'(s_axis_tuser[0]);
  assign in_set     = s_axis_tuser[1];
  assign in_byte    = s_axis_tdata[7:0];
  assign in_index   = s_axis_tdata[15:8];
  assign in_last    = s_axis_tlast;
  assign s_acc      = s_axis_tvalid && s_axis_tready;
  assign acc_stream = s_acc && (in_func == FUNC_STREAM);
  assign acc_read   = s_acc && (in_func == FUNC_READ);

  // --------------------------------------------------------------------------
  // Scan state
  // --------------------------------------------------------------------------
  logic [23:0]     hist_q, hist_d;
  logic [1:0]      fill_q, fill_d;
  logic            inside_q, inside_d;
  logic [23:0]     cnt_q, cnt_d;
  logic [4:0]      kind_q, kind_d;
  logic [23:0]     total_q, total_d;
  logic            idr_q, idr_d;
  logic [LenW-1:0] sps_len_q, sps_len_d;
  logic [LenW-1:0] pps_len_q, pps_len_d;

  logic            is_code;
  logic [23:0]     n_code;
  logic [4:0]      kind_eff;
  logic            fin_en;
  logic [23:0]     fin_n;
  logic [4:0]      fin_kind;
  logic [25:0]     sum;
  logic [23:0]     total_fin;
  logic            idr_fin;
  logic            sps_we;
  logic            pps_we;

  // Start-code detect and the NAL length it closes
  always_comb begin
    is_code  = (fill_q >= 2'd2) && (hist_q[15:0] == 16'h0000) && (in_byte == 8'h01);
    n_code   = (cnt_q >= 24'd2) ? (cnt_q - 24'd2) : 24'd0;
    if ((fill_q == 2'd3) && (hist_q[23:16] == 8'h00) && (cnt_q >= 24'd3)) begin
      n_code = cnt_q - 24'd3;
    end
    kind_eff = (cnt_q == 24'd0) ? (in_byte[4:0] & NalTypeMask) : kind_q;
  end

  // Next scan state
  always_comb begin
    hist_d    = hist_q;
    fill_d    = fill_q;
    inside_d  = inside_q;
    cnt_d     = cnt_q;
    kind_d    = kind_q;
    sps_len_d = sps_len_q;
    pps_len_d = pps_len_q;
    fin_en    = 1'b0;
    fin_n     = '0;
    fin_kind  = kind_q;
    sps_we    = 1'b0;
    pps_we    = 1'b0;

    if (acc_stream) begin
      if (is_code) begin
        fin_en   = inside_q;
        fin_n    = n_code;
        inside_d = 1'b1;
        cnt_d    = '0;
        kind_d   = '0;
      end else if (inside_q) begin
        kind_d = kind_eff;
        if (cnt_q < StoreLim) begin
          if (kind_eff == NalSps && sps_len_q == '0) begin
            sps_we = 1'b1;
          end else if (kind_eff == NalPps && pps_len_q == '0) begin
            pps_we = 1'b1;
          end
        end
        if (cnt_q < CntCap) begin
          cnt_d = cnt_q + 24'd1;
        end
        fin_en   = in_last;
        fin_n    = cnt_d;
        fin_kind = kind_eff;
      end
      hist_d = {hist_q[15:0], in_byte};
      if (fill_q != 2'd3) begin
        fill_d = fill_q + 2'd1;
      end
    end

    // Close a NAL: capture parameter-set length, flag IDR, add prefixed size of other NALs
    sum       = {2'b0, total_q} + {2'b0, PrefixBytes} + {2'b0, fin_n};
    total_fin = total_q;
    idr_fin   = idr_q;
    if (fin_en && fin_n != '0) begin
      if (fin_kind == NalSps && sps_len_q == '0 && fin_n <= StoreLim) begin
        sps_len_d = LenW'(fin_n);
      end else if (fin_kind == NalPps && pps_len_q == '0 && fin_n <= StoreLim) begin
        pps_len_d = LenW'(fin_n);
      end
      if (fin_kind == NalIdr) begin
        idr_fin = 1'b1;
      end
      if (fin_kind != NalSps && fin_kind != NalPps) begin
        total_fin = (sum[25:24] != 2'b00) ? LenMax : sum[23:0];
      end
    end

    total_d = total_fin;
    idr_d   = idr_fin;

    // Drop all per-chunk state after the summary
    if (acc_stream && in_last) begin
      hist_d   = '0;
      fill_d   = '0;
      inside_d = 1'b0;
      cnt_d    = '0;
      kind_d   = '0;
      total_d  = '0;
      idr_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= '0;
      fill_q    <= '0;
      inside_q  <= 1'b0;
      cnt_q     <= '0;
      kind_q    <= '0;
      total_q   <= '0;
      idr_q     <= 1'b0;
      sps_len_q <= '0;
      pps_len_q <= '0;
    end else begin
      hist_q    <= hist_d;
      fill_q    <= fill_d;
      inside_q  <= inside_d;
      cnt_q     <= cnt_d;
      kind_q    <= kind_d;
      total_q   <= total_d;
      idr_q     <= idr_d;
      sps_len_q <= sps_len_d;
      pps_len_q <= pps_len_d;
    end
  end

  // --------------------------------------------------------------------------
  // Parameter-set memories: one write or one registered read per cycle
  // --------------------------------------------------------------------------
  logic [7:0]       sps_mem [SetStoreBytes];
  logic [7:0]       pps_mem [SetStoreBytes];
  logic [7:0]       sps_rd_q;
  logic [7:0]       pps_rd_q;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;

  assign wr_addr = cnt_q[AddrW-1:0];
  assign rd_addr = AddrW'(in_index);

  always_ff @(posedge clk_i) begin
    if (sps_we) begin
      sps_mem[wr_addr] <= in_byte;
    end
    if (acc_read) begin
      sps_rd_q <= sps_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pps_we) begin
      pps_mem[wr_addr] <= in_byte;
    end
    if (acc_read) begin
      pps_rd_q <= pps_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Result stage: registered alongside the memory read data
  // --------------------------------------------------------------------------
  logic        s1_valid_q;
  kind_e       s1_kind_q;
  logic [23:0] s1_avcc_q;
  logic        s1_idr_q;
  logic [8:0]  s1_sps_q;
  logic [8:0]  s1_pps_q;
  logic        s1_set_q;
  logic        s1_idx_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc_read || (acc_stream && in_last);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_kind_q   <= acc_read ? KIND_READ : KIND_SUMMARY;
      s1_avcc_q   <= acc_read ? 24'd0 : total_fin;
      s1_idr_q    <= acc_read ? 1'b0 : idr_fin;
      s1_sps_q    <= 9'(sps_len_d);
      s1_pps_q    <= 9'(pps_len_d);
      s1_set_q    <= in_set;
      s1_idx_ok_q <= ({16'd0, in_index} < StoreLim);
    end
  end

  result_t s1_res;

  always_comb begin
    s1_res.kind        = s1_kind_q;
    s1_res.avcc_length = s1_avcc_q;
    s1_res.has_idr     = s1_idr_q;
    s1_res.sps_length  = s1_sps_q;
    s1_res.pps_length  = s1_pps_q;
    s1_res.read_byte   = '0;
    if (s1_kind_q == KIND_READ && s1_idx_ok_q) begin
      s1_res.read_byte = s1_set_q ? pps_rd_q : sps_rd_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  result_t          q_mem [QDepth];
  logic [QPtrW-1:0] q_wr_q;
  logic [QPtrW-1:0] q_rd_q;
  logic [QPtrW:0]   q_cnt_q;
  logic             q_push;
  logic             q_pop;
  logic [QPtrW:0]   pending;
  result_t          q_head;

  assign q_push  = s1_valid_q;
  assign q_pop   = m_axis_tvalid && m_axis_tready;
  assign pending = q_cnt_q + {{QPtrW{1'b0}}, s1_valid_q};
  // Keep room for the stage in flight plus one more accepted result
  assign s_axis_tready = (pending < (QPtrW + 1)'(QDepth - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      if (q_push) begin
        q_wr_q <= q_wr_q + 1'b1;
      end
      if (q_pop) begin
        q_rd_q <= q_rd_q + 1'b1;
      end
      q_cnt_q <= q_cnt_q + {{QPtrW{1'b0}}, q_push} - {{QPtrW{1'b0}}, q_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_push) begin
      q_mem[q_wr_q] <= s1_res;
    end
  end

  assign q_head        = q_mem[q_rd_q];
  assign m_axis_tvalid = (q_cnt_q != '0);
  assign m_axis_tuser  = q_head.kind;
  assign m_axis_tdata  = {5'd0, q_head.read_byte, q_head.pps_length, q_head.sps_length,
                          q_head.has_idr, q_head.avcc_length};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ANBS_ASSERT_NOW(a_q_no_overflow, s1_valid_q, q_cnt_q < (QPtrW + 1)'(QDepth),
    "result queue full while a result is in flight")
  `ANBS_ASSERT_NEXT(a_chunk_clear, acc_stream && in_last,
    !inside_q && total_q == '0 && fill_q == '0, "chunk state not cleared after summary")
  `ANBS_ASSERT_NEXT(a_read_result, acc_read, s1_valid_q && s1_kind_q == KIND_READ,
    "read transfer did not produce a read result")
  `ANBS_ASSERT_NEXT(a_no_spurious, acc_stream && !in_last, !s1_valid_q,
    "result produced by a byte that is not the chunk's last")

endmodule

`default_nettype wire

@@ dv/annexb_nal_scanner_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// annexb_nal_scanner_test
// Self-checking bench for the Annex-B NAL scanner. Directed chunks cover
// start-code forms, chunk edges and parameter-set capture; random chunks with
// interleaved store reads follow. A local scan predictor supplies the expected
// chunk summaries and read data; both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module annexb_nal_scanner_test
  import anbs_pkg::*;
();

  localparam int unsigned StoreBytes  = SetStoreBytesDefault;
  localparam int unsigned CountCap    =
    (MaxChunkBytesDefault < LenMax) ? MaxChunkBytesDefault : LenMax;
  localparam int unsigned RandomItems = 130;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 10;

  // Extra NAL types used by the stimulus
  localparam logic [4:0] NalSlice = 5'd1;
  localparam logic [4:0] NalSei   = 5'd6;
  localparam logic [4:0] NalAud   = 5'd9;

  // Store selectors
  localparam logic SelSps = 1'b0;
  localparam logic SelPps = 1'b1;

  typedef struct packed {
    func_e      func;
    logic [7:0] data_byte;
    logic       chunk_last;
    logic       set_select;
    logic [7:0] read_index;
  } scan_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [7:0] data_byte, [15:8] read_index
  logic        s_axis_tlast;   // chunk_last
  logic [1:0]  s_axis_tuser;   // [0] func, [1] set_select
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [23:0] avcc_length, [24] has_idr, [33:25] sps_length, [42:34] pps_length,
  // [50:43] read_byte
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;   // [0] result_kind

  annexb_nal_scanner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Predictor state
  logic [31:0] hist;
  logic [1:0]  fill;
  bit          in_unit;
  logic [23:0] unit_count;
  logic [4:0]  unit_type;
  logic [23:0] chunk_sum;
  bit          idr_flag;
  logic [7:0]  set_mem   [2][StoreBytes];
  bit          stored_ok [2][StoreBytes];
  logic [8:0]  set_len   [2];

  result_t     expected_results[$];
  logic [7:0]  chunk_bytes[$];

  int unsigned items_sent;
  int unsigned summaries_checked;
  int unsigned reads_checked;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          quiet;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------
  // Scan predictor
  // ------------------------------------------------------------------
  function automatic void clear_chunk();
    hist       = '0;
    fill       = '0;
    in_unit    = 1'b0;
    unit_count = '0;
    unit_type  = '0;
    chunk_sum  = '0;
    idr_flag   = 1'b0;
  endfunction

  // Account one finished NAL of n bytes
  function automatic void close_nal(int unsigned n);
    int unsigned sum;
    if (n == 0) return;
    if (unit_type == NalSps && set_len[SelSps] == 0 && n <= StoreBytes)
      set_len[SelSps] = 9'(n);
    else if (unit_type == NalPps && set_len[SelPps] == 0 && n <= StoreBytes)
      set_len[SelPps] = 9'(n);
    if (unit_type == NalIdr) idr_flag = 1'b1;
    if (unit_type != NalSps && unit_type != NalPps) begin
      sum = chunk_sum + PrefixBytes + n;
      chunk_sum = (sum > LenMax) ? LenMax : 24'(sum);
    end
  endfunction

  task automatic scan_predict(scan_item_t it);
    result_t     r;
    bit          is_code;
    int unsigned n;
    logic        sel;
    r = '0;
    r.sps_length = set_len[SelSps];
    r.pps_length = set_len[SelPps];
    // Store read: scan state untouched
    if (it.func == FUNC_READ) begin
      r.kind = KIND_READ;
      if (it.read_index < StoreBytes) r.read_byte = set_mem[it.set_select][it.read_index];
      expected_results.push_back(r);
      return;
    end
    is_code = fill >= 2 && hist[15:0] == 16'h0000 && it.data_byte == 8'h01;
    if (is_code) begin
      if (in_unit) begin
        n = (unit_count >= 2) ? unit_count - 2 : 0;
        // drop the extra zero of a four-byte start code
        if (fill >= 3 && hist[23:16] == 8'h00 && unit_count >= 3) n = n - 1;
        close_nal(n);
      end
      in_unit    = 1'b1;
      unit_count = '0;
      unit_type  = '0;
    end else if (in_unit) begin
      if (unit_count == 0) unit_type = it.data_byte[4:0] & NalTypeMask;
      if (unit_count < StoreBytes &&
          (unit_type == NalSps || unit_type == NalPps)) begin
        sel = (unit_type == NalPps) ? SelPps : SelSps;
        if (set_len[sel] == 0) begin
          set_mem[sel][unit_count[7:0]]   = it.data_byte;
          stored_ok[sel][unit_count[7:0]] = 1'b1;
        end
      end
      if (unit_count < CountCap) unit_count = unit_count + 24'd1;
    end
    hist = {hist[23:0], it.data_byte};
    if (fill < 3) fill = fill + 2'd1;
    // Chunk end: report the summary and clear per-chunk state
    if (it.chunk_last) begin
      if (in_unit) close_nal(unit_count);
      r.kind        = KIND_SUMMARY;
      r.avcc_length = chunk_sum;
      r.has_idr     = idr_flag;
      r.sps_length  = set_len[SelSps];
      r.pps_length  = set_len[SelPps];
      expected_results.push_back(r);
      clear_chunk();
    end
  endtask

  // ------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'({m_axis_tuser, m_axis_tdata[50:0]});
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual 0x%0h", $time, got);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", want.kind, got.kind);
        check_field("avcc_length", want.avcc_length, got.avcc_length);
        check_field("has_idr", want.has_idr, got.has_idr);
        check_field("sps_length", want.sps_length, got.sps_length);
        check_field("pps_length", want.pps_length, got.pps_length);
        check_field("read_byte", want.read_byte, got.read_byte);
        if (want.kind == KIND_READ) reads_checked++;
        else summaries_checked++;
      end
    end
  end

  // Output back-pressure: random stalls, mostly short, held off in quiet spells
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 15) begin
      stall_left    <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                   : $urandom_range(7, 39);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_results.size());
      $display("[annexb_nal_scanner] ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Drive one item and wait for its transfer, then predict it
  task automatic send_item(scan_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.read_index, it.data_byte};
    s_axis_tlast  <= it.chunk_last;
    s_axis_tuser  <= {it.set_select, it.func};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    scan_predict(it);
    items_sent++;
  endtask

  function automatic scan_item_t stream_item(logic [7:0] b, logic last);
    scan_item_t it;
    it.func       = FUNC_STREAM;
    it.data_byte  = b;
    it.chunk_last = last;
    it.set_select = 1'($urandom);
    it.read_index = 8'($urandom);
    return it;
  endfunction

  function automatic scan_item_t read_item(logic sel, logic [7:0] idx);
    scan_item_t it;
    it.func       = FUNC_READ;
    it.data_byte  = 8'($urandom);
    it.chunk_last = 1'($urandom);
    it.set_select = sel;
    it.read_index = idx;
    return it;
  endfunction

  // Pick a read of an entry that has been written; 0 if none found in 64 tries
  function automatic bit pick_read(output scan_item_t it);
    logic       sel;
    logic [7:0] idx;
    for (int k = 0; k < 64; k++) begin
      sel = 1'($urandom);
      idx = 8'($urandom);
      if (stored_ok[sel][idx]) begin
        it = read_item(sel, idx);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic add_code(bit four_byte);
    if (four_byte) chunk_bytes.push_back(8'h00);
    chunk_bytes.push_back(8'h00);
    chunk_bytes.push_back(8'h00);
    chunk_bytes.push_back(8'h01);
  endtask

  // Header byte plus payload; zero_pct sets how often a payload byte is zero
  task automatic add_nal(logic [4:0] kind, int unsigned payload, int unsigned zero_pct);
    logic [2:0] hi_bits;
    hi_bits = 3'($urandom);
    chunk_bytes.push_back({hi_bits, kind});
    repeat (payload) begin
      if ($urandom_range(0, 99) < zero_pct) chunk_bytes.push_back(8'h00);
      else chunk_bytes.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  // Send the queued chunk, marking its last byte, with reads mixed in
  task automatic send_chunk(int unsigned read_pct);
    scan_item_t it;
    for (int i = 0; i < chunk_bytes.size(); i++) begin
      if ($urandom_range(0, 99) < read_pct && pick_read(it)) send_item(it);
      send_item(stream_item(chunk_bytes[i], i == chunk_bytes.size() - 1));
    end
    chunk_bytes.delete();
  endtask

  function automatic logic [4:0] pick_nal_type();
    case ($urandom_range(0, 9))
      0, 1:    return NalSlice;
      2, 3:    return NalIdr;
      4:       return NalSps;
      5:       return NalPps;
      6:       return NalSei;
      7:       return NalAud;
      default: return 5'($urandom);
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // Start-code forms, leading junk, chunk edges and empty NALs
  task automatic test_directed();
    // junk, four-byte code, IDR, three-byte code, slice
    chunk_bytes = '{8'hff, 8'h00, 8'h00, 8'h00, 8'h01, {3'b011, NalIdr}, 8'h88, 8'h84,
                    8'h00, 8'h00, 8'h01, {3'b010, NalSlice}, 8'h9a};
    send_chunk(0);
    // one-byte chunk of zero
    chunk_bytes = '{8'h00};
    send_chunk(0);
    // start code on the last byte
    chunk_bytes = '{8'h00, 8'h00, 8'h01, {3'b000, NalAud}, 8'hf0, 8'h00, 8'h00, 8'h01};
    send_chunk(0);
    // chunk ends in zeros; the next one opens with 01, which is no code
    chunk_bytes = '{8'h00, 8'h00, 8'h01, {3'b010, NalSlice}, 8'hff, 8'h00, 8'h00};
    send_chunk(0);
    chunk_bytes = '{8'h01, 8'h21, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01,
                    {3'b000, NalSei}, 8'hff};
    send_chunk(0);
  endtask

  // Oversized sets, exact-size capture and store read-back
  task automatic test_param_sets();
    // too long: not captured, but both stores fill completely
    add_code(1'b0);
    add_nal(NalSps, $urandom_range(StoreBytes, StoreBytes + 40), 0);
    add_code(1'b1);
    add_nal(NalAud, 1, 0);
    send_chunk(0);
    add_code(1'b1);
    add_nal(NalPps, $urandom_range(StoreBytes, StoreBytes + 40), 0);
    send_chunk(0);
    // SPS of exactly the store size, short PPS, IDR
    add_code(1'b1);
    add_nal(NalSps, StoreBytes - 1, 0);
    add_code(1'b0);
    add_nal(NalPps, $urandom_range(0, 30), 0);
    add_code(1'b0);
    add_nal(NalIdr, $urandom_range(0, 20), 0);
    send_chunk(0);
    // read both ends of both stores, then a spread
    send_item(read_item(SelSps, 8'h00));
    send_item(read_item(SelSps, 8'hff));
    send_item(read_item(SelPps, 8'h00));
    send_item(read_item(SelPps, 8'hff));
    repeat (20) send_item(read_item(1'($urandom), 8'($urandom)));
  endtask

  // Mostly well-formed chunks with random content, some noise
  task automatic test_random();
    int unsigned first_item;
    int unsigned units;
    first_item = items_sent;
    while (items_sent - first_item < RandomItems) begin
      quiet = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 99) < 12) begin
        // noise rich in zeros and ones
        repeat ($urandom_range(1, 24)) begin
          case ($urandom_range(0, 4))
            0, 1:    chunk_bytes.push_back(8'h00);
            2:       chunk_bytes.push_back(8'h01);
            default: chunk_bytes.push_back(8'($urandom));
          endcase
        end
      end else begin
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) chunk_bytes.push_back(8'($urandom));
        units = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
        repeat (units) begin
          add_code($urandom_range(0, 99) < 40);
          add_nal(pick_nal_type(),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(21, 120)
                                              : $urandom_range(0, 20), 3);
        end
        if ($urandom_range(0, 9) == 0) add_code(1'($urandom_range(0, 1)));
      end
      if (chunk_bytes.size() == 0) chunk_bytes.push_back(8'($urandom));
      send_chunk(8);
    end
    quiet = 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = '0;
    quiet         = 1'b0;
    set_len[SelSps] = '0;
    set_len[SelPps] = '0;
    clear_chunk();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_param_sets();
    test_random();
    s_axis_tvalid <= 1'b0;

    // drain, then allow the pipeline to settle
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d items; checked %0d chunk summaries and %0d store reads.",
             items_sent, summaries_checked, reads_checked);
    $display("Captured SPS %0d bytes, PPS %0d bytes; %0d mismatches.",
             set_len[SelSps], set_len[SelPps], fail_count);
    if (fail_count == 0) begin
      $display("[annexb_nal_scanner] OK");
    end else begin
      $display("[annexb_nal_scanner] ERROR");
    end
    $finish;
  end

endmodule
